### rtl/motor_torque_command_encoder_macros.svh
// Assertion macros for the motor torque command encoder.
`ifndef MOTOR_TORQUE_COMMAND_ENCODER_MACROS_SVH
`define MOTOR_TORQUE_COMMAND_ENCODER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define MTCE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define MTCE_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define MTCE_ASSERT(lbl, prop, msg)
`define MTCE_ASSERT_RST(lbl, prop, msg)
`endif

`endif

### rtl/mtce_pkg.sv
package mtce_pkg;

   localparam int ID_W       = 11;
   localparam int LEN_W      = 4;
   localparam int DATA_W     = 64;
   localparam int TORQUE_W   = 32;
   localparam int CMD_W      = 2;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int DIVIDEND_W = 48;
   localparam int DIVISOR_W  = 32;
   localparam int JL_W       = 47;

   localparam logic [LEN_W-1:0]  FRAME_LEN         = 4'd8;
   localparam logic [DATA_W-1:0] FRAME_ENABLE      = 64'hffff_ffff_ffff_fffc;
   localparam logic [DATA_W-1:0] FRAME_DISABLE     = 64'hffff_ffff_ffff_fffd;
   localparam logic [DATA_W-1:0] FRAME_TORQUE_HEAD = 64'h8000_8000_0000_0000;
   localparam logic [16:0]       EFF_ONE           = 17'h10000;
   localparam logic [31:0]       TORQUE_SAT        = 32'h7fff_ffff;

   typedef enum logic [CMD_W-1:0] {
      CMD_TORQUE  = 2'd0,
      CMD_ENABLE  = 2'd1,
      CMD_DISABLE = 2'd2,
      CMD_UNUSED  = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 2'd0,
      ST_CLAMPED    = 2'd1,
      ST_BAD_CONFIG = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BUS_ID       = 3'd0,
      REG_MOTOR_NUMBER = 3'd1,
      REG_GEAR         = 3'd2,
      REG_EFFICIENCY   = 3'd3,
      REG_TORQUE_LIMIT = 3'd4,
      REG_TORQUE_MAX   = 3'd5,
      REG_REVERSE      = 3'd6
   } reg_type;

   typedef struct packed {
      logic [10:0] bus_id;
      logic [3:0]  motor_number;
      logic [31:0] gear;
      logic [16:0] efficiency;
      logic [30:0] torque_limit;
      logic [30:0] torque_max;
      logic        reverse;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      bus_id:       11'd1,
      motor_number: 4'd1,
      gear:         32'h0001_0000,
      efficiency:   17'h10000,
      torque_limit: 31'h0001_0000,
      torque_max:   31'h000a_0000,
      reverse:      1'b0
   };

   typedef struct packed {
      cmd_type     kind;
      logic        neg;
      logic [31:0] mag;
   } item_type;

   typedef struct packed {
      logic [ID_W-1:0]     frame_id;
      logic [LEN_W-1:0]    frame_len;
      logic [DATA_W-1:0]   frame_data;
      logic [TORQUE_W-1:0] applied_torque;
      status_type          status;
   } rsp_type;

   typedef struct packed {
      logic stale;
      logic result_load;
   } back_stat_type;

endpackage

### rtl/mtce_ifs.sv
interface mtce_req_if;
   logic                              valid;
   logic                              ready;
   logic [mtce_pkg::CMD_W-1:0]        cmd;
   logic signed [mtce_pkg::TORQUE_W-1:0] joint_torque;

   modport source (output valid, cmd, joint_torque, input ready);
   modport sink (input valid, cmd, joint_torque, output ready);
endinterface

interface mtce_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [mtce_pkg::ID_W-1:0]         frame_id;
   logic [mtce_pkg::LEN_W-1:0]        frame_len;
   logic [mtce_pkg::DATA_W-1:0]       frame_data;
   logic signed [mtce_pkg::TORQUE_W-1:0] applied_torque;
   logic [mtce_pkg::STATUS_W-1:0]     status;

   modport source (output valid, frame_id, frame_len, frame_data, applied_torque, status,
                   input ready);
   modport sink (input valid, frame_id, frame_len, frame_data, applied_torque, status,
                 output ready);
endinterface

### rtl/mtce_front.sv
module mtce_front (
   input  logic               clock,
   input  logic               reset,
   mtce_req_if.sink           req,
   output mtce_pkg::item_type q_item,
   output logic               q_valid,
   input  logic               q_pop
);
   import mtce_pkg::*;

   localparam int DEPTH = 2;

   item_type   entry_ff [DEPTH];
   item_type   entry_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   // classify: command kind, sign and magnitude of the torque
   always_comb begin
      entry_in.kind = cmd_type'(req.cmd);
      entry_in.neg  = req.joint_torque[TORQUE_W-1];
      entry_in.mag  = entry_in.neg ? (~req.joint_torque + 32'd1) : req.joint_torque;
      push      = req.valid && req.ready;
      pop       = q_pop && q_valid;
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   assign req.ready = (count_ff != 2'(DEPTH));
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

### rtl/mtce_div.sv
module mtce_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [mtce_pkg::DIVIDEND_W-1:0]    dividend,
   input  logic [mtce_pkg::DIVISOR_W-1:0]     divisor,
   output logic                               busy,
   output logic [mtce_pkg::DIVIDEND_W-1:0]    quotient
);
   import mtce_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] q_ff, q_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;

   // restoring divide, one quotient bit per cycle
   always_comb begin
      trial  = {rem_ff, q_ff[DIVIDEND_W-1]};
      diff   = trial - {1'b0, dsr_ff};
      rem_in = rem_ff;
      q_in   = q_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = '0;
         q_in   = dividend;
         dsr_in = divisor;
         cnt_in = CNT_W'(DIVIDEND_W);
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = diff[DIVISOR_W-1:0];
            q_in   = {q_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVISOR_W-1:0];
            q_in   = {q_ff[DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   assign busy     = (cnt_ff != '0);
   assign quotient = q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      dsr_ff <= dsr_in;
   end

endmodule

### rtl/mtce_back.sv
module mtce_back #(
   parameter int CODE_BITS = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mtce_pkg::cfg_type       cfg,
   input  logic                    cfg_write,
   input  mtce_pkg::item_type      q_item,
   input  logic                    q_valid,
   output logic                    q_pop,
   mtce_rsp_if.source              rsp,
   output mtce_pkg::back_stat_type stat
);
   import mtce_pkg::*;

   localparam logic [CODE_BITS-1:0] CM = '1;
   localparam int DIFF_W = CODE_BITS + 1;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH,
      D_GQ, D_JL, D_LIM, D_LOWM, D_LOWD, D_LOWW, D_HIGHW,
      T_CLIP, T_MDIV, T_CDIV, T_CWAIT, T_DMUL, T_DDIV, T_DWAIT, T_APPLY,
      S_FINISH
   } state_type;

   state_type             state_ff, state_in;
   logic                  stale_ff, stale_in;
   item_type              item_ff, item_in;
   logic [31:0]           gq_ff, gq_in;
   logic [JL_W-1:0]       jl_ff, jl_in;
   logic                  lim_ok_ff, lim_ok_in;
   logic                  cfg_ok_ff, cfg_ok_in;
   logic [CODE_BITS-1:0]  low_ff, low_in;
   logic [CODE_BITS-1:0]  high_ff, high_in;
   logic [63:0]           prod_ff, prod_in;
   logic                  clamped_ff, clamped_in;
   logic [CODE_BITS-1:0]  code_ff, code_in;
   logic                  dneg_ff, dneg_in;
   logic [DIVIDEND_W-1:0] dx_ff, dx_in;
   logic [DIVIDEND_W-1:0] dq_ff, dq_in;
   rsp_type               res_ff, res_in;
   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_ff, out_in;

   logic [31:0]           mul_a, mul_b;
   logic                  div_start;
   logic [DIVIDEND_W-1:0] div_dividend;
   logic [DIVISOR_W-1:0]  div_divisor;
   logic                  div_busy;
   logic [DIVIDEND_W-1:0] div_quot;

   logic [31:0]           two_m, tm32, tl32;
   logic                  mneg;
   logic [31:0]           mpos;
   logic [CODE_BITS-1:0]  code_raw;
   logic [DIFF_W-1:0]     twice_code, cm_ext, abs_diff;
   logic                  dneg;
   logic [DIVIDEND_W-1:0] dx_hi;
   logic [DIVIDEND_W-1:0] dfin;
   logic [JL_W-1:0]       a_val;
   logic                  a_sat;
   logic [31:0]           a_mag;
   logic                  aneg;
   logic                  load;
   logic [31:0]           mag_clip;
   logic                  mag_over;

   mtce_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quot)
   );

   always_comb begin
      two_m      = {cfg.torque_max, 1'b0};
      tm32       = {1'b0, cfg.torque_max};
      tl32       = {1'b0, cfg.torque_limit};
      mneg       = item_ff.neg ^ cfg.reverse;
      mpos       = mneg ? (tm32 - {1'b0, div_quot[30:0]}) : (tm32 + {1'b0, div_quot[30:0]});
      code_raw   = div_quot[CODE_BITS-1:0];
      twice_code = {code_ff, 1'b0};
      cm_ext     = {1'b0, CM};
      dneg       = (twice_code < cm_ext);
      abs_diff   = dneg ? (cm_ext - twice_code) : (twice_code - cm_ext);
      // divide by 2^CODE_BITS-1: x = hi*2^B + lo gives x/CM = hi + (hi + lo)/CM
      dx_hi      = dx_ff >> CODE_BITS;
      dfin       = dq_ff + DIVIDEND_W'(dx_ff == DIVIDEND_W'(CM));
      a_val      = prod_ff[62:16];
      a_sat      = (a_val > JL_W'(TORQUE_SAT));
      a_mag      = a_sat ? TORQUE_SAT : a_val[31:0];
      aneg       = dneg_ff ^ cfg.reverse;
      mag_over   = (JL_W'(item_ff.mag) > jl_ff);
      mag_clip   = mag_over ? jl_ff[31:0] : item_ff.mag;
      load       = (state_ff == S_FINISH) && (!out_valid_ff || rsp.ready);

      // shared multiplier operands
      case (state_ff)
         D_GQ:            begin mul_a = cfg.gear;         mul_b = 32'(cfg.efficiency); end
         D_JL:            begin mul_a = tl32;             mul_b = prod_ff[47:16];      end
         D_LIM:           begin mul_a = tl32;             mul_b = 32'(CM);             end
         D_LOWM:          begin mul_a = tm32 - tl32;      mul_b = 32'(CM);             end
         D_LOWD, D_LOWW:  begin mul_a = tm32 + tl32;      mul_b = 32'(CM);             end
         T_MDIV:          begin mul_a = mpos;             mul_b = 32'(CM);             end
         T_DMUL:          begin mul_a = 32'(abs_diff);    mul_b = tm32;                end
         T_DWAIT:         begin mul_a = {1'b0, dfin[30:0]}; mul_b = gq_ff;             end
         default:         begin mul_a = 32'd0;            mul_b = 32'd0;               end
      endcase
      prod_in = {32'd0, mul_a} * {32'd0, mul_b};

      state_in     = state_ff;
      stale_in     = stale_ff;
      item_in      = item_ff;
      gq_in        = gq_ff;
      jl_in        = jl_ff;
      lim_ok_in    = lim_ok_ff;
      cfg_ok_in    = cfg_ok_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      clamped_in   = clamped_ff;
      code_in      = code_ff;
      dneg_in      = dneg_ff;
      dx_in        = dx_ff;
      dq_in        = dq_ff;
      res_in       = res_ff;
      q_pop        = 1'b0;
      div_start    = 1'b0;
      div_dividend = prod_ff[DIVIDEND_W-1:0];
      div_divisor  = two_m;

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop      = 1'b1;
               item_in    = q_item;
               clamped_in = 1'b0;
               state_in   = stale_ff ? D_GQ : S_DISPATCH;
            end
         end
         D_GQ:   state_in = D_JL;
         D_JL: begin
            gq_in    = prod_ff[47:16];
            state_in = D_LIM;
         end
         D_LIM: begin
            jl_in    = prod_ff[62:16];
            state_in = D_LOWM;
         end
         D_LOWM: begin
            lim_ok_in = (prod_ff[DIVIDEND_W-1:0] >= DIVIDEND_W'(cfg.torque_max));
            state_in  = D_LOWD;
         end
         D_LOWD: begin
            // ceiling of the lower code bound
            div_start    = 1'b1;
            div_dividend = prod_ff[DIVIDEND_W-1:0] + DIVIDEND_W'(two_m) - 48'd1;
            state_in     = D_LOWW;
         end
         D_LOWW: begin
            if (!div_busy) begin
               low_in    = code_raw;
               div_start = 1'b1;
               state_in  = D_HIGHW;
            end
         end
         D_HIGHW: begin
            if (!div_busy) begin
               high_in   = code_raw;
               cfg_ok_in = (cfg.bus_id[3:0] == cfg.motor_number)
                           && (cfg.gear != '0) && (cfg.efficiency != '0)
                           && (cfg.efficiency <= EFF_ONE)
                           && (cfg.torque_limit != '0) && (cfg.torque_max != '0)
                           && (cfg.torque_limit <= cfg.torque_max)
                           && lim_ok_ff && (gq_ff != '0) && (jl_ff != '0);
               stale_in  = 1'b0;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            res_in.frame_id       = '0;
            res_in.frame_len      = '0;
            res_in.frame_data     = '0;
            res_in.applied_torque = '0;
            res_in.status         = ST_BAD_CONFIG;
            state_in              = S_FINISH;
            if (cfg_ok_ff) begin
               case (item_ff.kind)
                  CMD_ENABLE: begin
                     res_in.frame_id   = cfg.bus_id;
                     res_in.frame_len  = FRAME_LEN;
                     res_in.frame_data = FRAME_ENABLE;
                     res_in.status     = ST_OK;
                  end
                  CMD_DISABLE: begin
                     res_in.frame_id   = cfg.bus_id;
                     res_in.frame_len  = FRAME_LEN;
                     res_in.frame_data = FRAME_DISABLE;
                     res_in.status     = ST_OK;
                  end
                  CMD_TORQUE: state_in = T_CLIP;
                  default: ;
               endcase
            end
         end
         T_CLIP: begin
            clamped_in   = mag_over;
            div_start    = 1'b1;
            div_dividend = {mag_clip, 16'd0};
            div_divisor  = gq_ff;
            state_in     = T_MDIV;
         end
         T_MDIV: begin
            if (!div_busy) begin
               state_in = T_CDIV;
            end
         end
         T_CDIV: begin
            div_start    = 1'b1;
            div_dividend = prod_ff[DIVIDEND_W-1:0] + DIVIDEND_W'(cfg.torque_max);
            state_in     = T_CWAIT;
         end
         T_CWAIT: begin
            if (!div_busy) begin
               if (code_raw < low_ff) begin
                  code_in    = low_ff;
                  clamped_in = 1'b1;
               end else if (code_raw > high_ff) begin
                  code_in    = high_ff;
                  clamped_in = 1'b1;
               end else begin
                  code_in = code_raw;
               end
               state_in = T_DMUL;
            end
         end
         T_DMUL: begin
            dneg_in  = dneg;
            state_in = T_DDIV;
         end
         T_DDIV: begin
            dx_in    = prod_ff[DIVIDEND_W-1:0];
            dq_in    = '0;
            state_in = T_DWAIT;
         end
         T_DWAIT: begin
            if (dx_hi != '0) begin
               dq_in = dq_ff + dx_hi;
               dx_in = dx_hi + (dx_ff & DIVIDEND_W'(CM));
            end else begin
               state_in = T_APPLY;
            end
         end
         T_APPLY: begin
            res_in.frame_id       = cfg.bus_id;
            res_in.frame_len      = FRAME_LEN;
            res_in.frame_data     = FRAME_TORQUE_HEAD | DATA_W'(code_ff);
            res_in.applied_torque = aneg ? (~a_mag + 32'd1) : a_mag;
            res_in.status         = (clamped_ff || a_sat) ? ST_CLAMPED : ST_OK;
            state_in              = S_FINISH;
         end
         S_FINISH: begin
            if (load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (cfg_write) begin
         stale_in = 1'b1;
      end

      out_in       = load ? res_ff : out_ff;
      out_valid_in = load ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_ff);
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.frame_id       = out_ff.frame_id;
   assign rsp.frame_len      = out_ff.frame_len;
   assign rsp.frame_data     = out_ff.frame_data;
   assign rsp.applied_torque = out_ff.applied_torque;
   assign rsp.status         = out_ff.status;

   assign stat.stale       = stale_ff;
   assign stat.result_load = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         stale_ff     <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stale_ff     <= stale_in;
         out_valid_ff <= out_valid_in;
      end
      item_ff    <= item_in;
      gq_ff      <= gq_in;
      jl_ff      <= jl_in;
      lim_ok_ff  <= lim_ok_in;
      cfg_ok_ff  <= cfg_ok_in;
      low_ff     <= low_in;
      high_ff    <= high_in;
      prod_ff    <= prod_in;
      clamped_ff <= clamped_in;
      code_ff    <= code_in;
      dneg_ff    <= dneg_in;
      dx_ff      <= dx_in;
      dq_ff      <= dq_in;
      res_ff     <= res_in;
      out_ff     <= out_in;
   end

endmodule

### rtl/motor_torque_command_encoder.sv
// Motor torque command encoder: turns each command item into one response, an 8-byte
// bus frame unless the configuration is invalid or the command is unused. Enable and
// disable items, and any item under an invalid configuration, go straight from dispatch
// to the result; a torque item makes two passes through the single radix-2 divider
// (motor torque, code), and decoding the code back takes shift-and-add steps. After
// reset or any register write, the first item also rederives gain, joint limit and code
// bounds (two more divider passes). A two-item input queue and an output register let
// the input side keep taking items while a result waits.
`include "motor_torque_command_encoder_macros.svh"

module motor_torque_command_encoder #(
   parameter int CODE_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   mtce_req_if.sink                            req_ch,
   mtce_rsp_if.source                          rsp_ch,
   input  logic                                csr_we,
   input  logic [mtce_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mtce_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import mtce_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   item_type      q_item;
   logic          q_valid;
   logic          q_pop;
   back_stat_type back_stat;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (reg_type'(csr_index))
            REG_BUS_ID:       cfg_in.bus_id       = csr_wdata[10:0];
            REG_MOTOR_NUMBER: cfg_in.motor_number = csr_wdata[3:0];
            REG_GEAR:         cfg_in.gear         = csr_wdata;
            REG_EFFICIENCY:   cfg_in.efficiency   = csr_wdata[16:0];
            REG_TORQUE_LIMIT: cfg_in.torque_limit = csr_wdata[30:0];
            REG_TORQUE_MAX:   cfg_in.torque_max   = csr_wdata[30:0];
            REG_REVERSE:      cfg_in.reverse      = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mtce_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .q_item  (q_item),
      .q_valid (q_valid),
      .q_pop   (q_pop)
   );

   mtce_back #(
      .CODE_BITS (CODE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cfg_write (csr_we),
      .q_item    (q_item),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .rsp       (rsp_ch),
      .stat      (back_stat)
   );

   `MTCE_ASSERT(a_write_marks_stale, csr_we |=> back_stat.stale, "register write not seen")
   `MTCE_ASSERT(a_load_shows_item, back_stat.result_load |=> rsp_ch.valid, "result lost")
   `MTCE_ASSERT(a_no_overwrite, back_stat.result_load && rsp_ch.valid |-> rsp_ch.ready,
                "result overwritten")
   `MTCE_ASSERT_RST(a_reset_state, reset |=> !rsp_ch.valid && back_stat.stale,
                    "bad state after reset")

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import mtce_pkg::*;

   localparam int  CODE_BITS   = 12;
   localparam int  CYCLE_LIMIT = 3000000;
   localparam int  DRAIN_WAIT  = 400;

   typedef struct packed {
      cmd_type     kind;
      logic [31:0] torque;
   } cmd_item;

   logic clock;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   mtce_req_if req_if();
   mtce_rsp_if rsp_if();

   motor_torque_command_encoder #(.CODE_BITS(CODE_BITS)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   cmd_item pending_cmds[$];
   rsp_type expected_frames[$];
   cfg_type cfg_now;
   int      errors;
   int      cycle_count;
   int      burst_left;
   int      gap_left;
   int      stall_mode;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit [63:0] gain_of(cfg_type c);
      bit [63:0] gr, ef;
      gr = c.gear;
      ef = c.efficiency;
      return (gr * ef) >> 16;
   endfunction

   function automatic bit [63:0] joint_lim(cfg_type c);
      bit [63:0] tl;
      tl = c.torque_limit;
      return (tl * gain_of(c)) >> 16;
   endfunction

   function automatic rsp_type encode_frame(cfg_type c, cmd_type k, logic [31:0] raw);
      bit [63:0] cm, gq, jl, tl, tm, mag, m, mpos, two_m, code, lo, hi, d, a;
      longint    diff;
      bit        neg, mneg, aneg, clamped, ok;
      rsp_type   r;
      cm = (64'd1 << CODE_BITS) - 1;
      tl = c.torque_limit;
      tm = c.torque_max;
      gq = gain_of(c);
      jl = joint_lim(c);
      r = '0;
      r.status = ST_BAD_CONFIG;
      ok = ({7'd0, c.bus_id[3:0]} == {7'd0, c.motor_number}) && c.gear != 0
         && c.efficiency != 0 && c.efficiency <= EFF_ONE && tl != 0 && tm != 0
         && tl <= tm && tl * cm >= tm && gq != 0 && jl != 0;
      if (k == CMD_UNUSED || !ok) return r;
      r.frame_id  = c.bus_id;
      r.frame_len = FRAME_LEN;
      r.status    = ST_OK;
      if (k == CMD_ENABLE) begin
         r.frame_data = FRAME_ENABLE;
         return r;
      end
      if (k == CMD_DISABLE) begin
         r.frame_data = FRAME_DISABLE;
         return r;
      end
      neg = raw[31];
      mag = neg ? (64'h1_0000_0000 - raw) : raw;
      clamped = 1'b0;
      if (mag > jl) begin
         mag = jl;
         clamped = 1'b1;
      end
      m = (mag << 16) / gq;
      mneg = neg ^ c.reverse;
      mpos = mneg ? tm - m : tm + m;
      two_m = 2 * tm;
      code = (mpos * cm + tm) / two_m;
      lo = ((tm - tl) * cm + two_m - 1) / two_m;
      hi = ((tm + tl) * cm) / two_m;
      if (code < lo) begin
         code = lo;
         clamped = 1'b1;
      end
      if (code > hi) begin
         code = hi;
         clamped = 1'b1;
      end
      diff = 2 * longint'(code) - longint'(cm);
      d = ((diff < 0) ? 64'(-diff) : 64'(diff)) * tm / cm;
      a = (d * gq) >> 16;
      aneg = (diff < 0) ^ c.reverse;
      if (a > 64'h7fff_ffff) begin
         a = 64'h7fff_ffff;
         clamped = 1'b1;
      end
      r.frame_data = FRAME_TORQUE_HEAD | {48'd0, code[15:0]};
      r.applied_torque = aneg ? 32'(64'h1_0000_0000 - a) : a[31:0];
      r.status = clamped ? ST_CLAMPED : ST_OK;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
   endtask

   // driver: bursts with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         burst_left <= 4;
         gap_left <= 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_frames.push_back(encode_frame(cfg_now, cmd_type'(req_if.cmd),
                                                   req_if.joint_torque));
            void'(pending_cmds.pop_front());
         end
         if (!(req_if.valid && !req_if.ready)) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_if.valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
               req_if.valid <= 1'b1;
               req_if.cmd <= pending_cmds[0].kind;
               req_if.joint_torque <= pending_cmds[0].torque;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 12);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: own stall pattern, checks against the oldest expected frame
   always @(posedge clock) begin
      rsp_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout");
         $display("TEST FAILED");
         $finish;
      end
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_mode <= 0;
      end else begin
         if (cycle_count % 97 == 0) stall_mode <= $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= $urandom_range(0, 1);
            2: rsp_if.ready <= ($urandom_range(0, 5) == 0);
            default: rsp_if.ready <= ((cycle_count % 16) < 11);
         endcase
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_frames.size() == 0) begin
               report_mismatch("unexpected frame", rsp_if.frame_data, 64'd0);
            end else begin
               want = expected_frames.pop_front();
               if (rsp_if.frame_id !== want.frame_id)
                  report_mismatch("frame_id", 64'(rsp_if.frame_id), 64'(want.frame_id));
               if (rsp_if.frame_len !== want.frame_len)
                  report_mismatch("frame_len", 64'(rsp_if.frame_len), 64'(want.frame_len));
               if (rsp_if.frame_data !== want.frame_data)
                  report_mismatch("frame_data", rsp_if.frame_data, want.frame_data);
               if (rsp_if.applied_torque !== want.applied_torque)
                  report_mismatch("applied_torque", 64'(unsigned'(rsp_if.applied_torque)),
                                  64'(want.applied_torque));
               if (rsp_if.status !== want.status)
                  report_mismatch("status", 64'(rsp_if.status), 64'(want.status));
            end
         end
      end
   end

   task automatic write_config(cfg_type c);
      logic [CSR_DATA_W-1:0] vals[7];
      vals[REG_BUS_ID]       = 32'(c.bus_id);
      vals[REG_MOTOR_NUMBER] = 32'(c.motor_number);
      vals[REG_GEAR]         = c.gear;
      vals[REG_EFFICIENCY]   = 32'(c.efficiency);
      vals[REG_TORQUE_LIMIT] = 32'(c.torque_limit);
      vals[REG_TORQUE_MAX]   = 32'(c.torque_max);
      vals[REG_REVERSE]      = 32'(c.reverse);
      for (int i = 0; i < 7; i++) begin
         @(posedge clock);
         csr_we <= 1'b1;
         csr_index <= i[CSR_IDX_W-1:0];
         csr_wdata <= vals[i];
      end
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_now = c;
   endtask

   task automatic wait_drained();
      while (pending_cmds.size() > 0 || req_if.valid || expected_frames.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_torque(cfg_type c);
      bit [63:0]   jl;
      logic [31:0] v;
      jl = joint_lim(c);
      case ($urandom_range(0, 3))
         0: v = $urandom;
         1: begin
            if (jl > 64'h7fff_fff0) jl = 64'h7fff_fff0;
            v = jl[31:0] + $urandom_range(0, 4) - 2;
         end
         2: v = $urandom_range(0, 32'h0004_0000);
         default: v = jl[31:0] / $urandom_range(1, 8);
      endcase
      if ($urandom_range(0, 1)) v = -v;
      return v;
   endfunction

   function automatic cmd_item pick_item(cfg_type c);
      cmd_item it;
      int      r;
      r = $urandom_range(0, 19);
      it.kind = (r < 14) ? CMD_TORQUE : (r < 17) ? CMD_ENABLE :
                (r < 19) ? CMD_DISABLE : CMD_UNUSED;
      it.torque = pick_torque(c);
      return it;
   endfunction

   function automatic cfg_type random_valid_cfg();
      cfg_type     c;
      logic [30:0] lo;
      c.torque_max = 31'(($urandom_range(0, 2) == 0) ? $urandom
                                                      : $urandom_range(4095, 32'h0100_0000));
      if (c.torque_max < 4095) c.torque_max = 31'd4095;
      lo = 31'((32'(c.torque_max) + 32'd4094) / 32'd4095);
      c.torque_limit = 31'($urandom_range(32'(lo), 32'(c.torque_max)));
      c.gear = $urandom_range(32'h0000_4000, 32'h0040_0000);
      c.efficiency = 17'($urandom_range(1, 65536));
      c.bus_id = 11'($urandom);
      c.motor_number = c.bus_id[3:0];
      c.reverse = 1'($urandom);
      return c;
   endfunction

   task automatic push_directed(cfg_type c);
      bit [63:0] jl;
      logic [31:0] vals[11];
      jl = joint_lim(c);
      if (jl > 64'h7fff_fffe) jl = 64'h7fff_fffe;
      vals = '{32'd0, 32'd1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, jl[31:0],
               jl[31:0] + 1, -jl[31:0], -(jl[31:0] + 1), jl[31:0] / 2, 32'h0000_8000};
      foreach (vals[i]) pending_cmds.push_back('{CMD_TORQUE, vals[i]});
      pending_cmds.push_back('{CMD_ENABLE, 32'h8000_0000});
      pending_cmds.push_back('{CMD_DISABLE, 32'h7fff_ffff});
      pending_cmds.push_back('{CMD_UNUSED, 32'h0001_0000});
   endtask

   task automatic run_phase(cfg_type c, int n_items, bit directed);
      write_config(c);
      if (directed) push_directed(c);
      repeat (n_items) pending_cmds.push_back(pick_item(c));
      wait_drained();
   endtask

   initial begin
      cfg_type c;
      reset = 1'b1;
      errors = 0;
      cycle_count = 0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.cmd = CMD_TORQUE;
      req_if.joint_torque = '0;
      rsp_if.ready = 1'b0;
      cfg_now = CFG_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      push_directed(CFG_RESET);
      repeat (40) pending_cmds.push_back(pick_item(CFG_RESET));
      wait_drained();

      c = CFG_RESET; c.reverse = 1'b1;
      run_phase(c, 40, 1'b0);

      // extremes, applied torque saturates
      c = '{11'h7ff, 4'hf, 32'hffff_ffff, 17'h10000, 31'h7fff_ffff, 31'h7fff_ffff, 1'b0};
      run_phase(c, 40, 1'b1);
      c.reverse = 1'b1; c.torque_limit = 31'h4000_0000;
      run_phase(c, 30, 1'b0);

      // tightest limit
      c = '{11'h000, 4'h0, 32'h0002_0000, 17'h8000, 31'd161, 31'd655350, 1'b0};
      run_phase(c, 30, 1'b0);
      c = '{11'h2a5, 4'h5, 32'hffff_ffff, 17'd1, 31'h0001_0000, 31'h0004_0000, 1'b1};
      run_phase(c, 30, 1'b0);

      // invalid settings
      c = CFG_RESET; c.motor_number = 4'h2;            run_phase(c, 12, 1'b0);
      c = CFG_RESET; c.gear = 32'd0;                   run_phase(c, 8, 1'b0);
      c = CFG_RESET; c.efficiency = 17'd0;             run_phase(c, 8, 1'b0);
      c = CFG_RESET; c.efficiency = 17'h1ffff;         run_phase(c, 8, 1'b0);
      c = CFG_RESET; c.torque_limit = 31'd0;           run_phase(c, 8, 1'b0);
      c = CFG_RESET; c.torque_max = 31'd0;             run_phase(c, 8, 1'b0);
      c = CFG_RESET; c.torque_limit = 31'h000b_0000;   run_phase(c, 8, 1'b0);
      c = CFG_RESET; c.torque_limit = 31'd100;         run_phase(c, 8, 1'b0);
      c = CFG_RESET; c.gear = 32'd1; c.efficiency = 17'd1;
      run_phase(c, 8, 1'b0);
      c = CFG_RESET; c.gear = 32'd1; c.torque_limit = 31'd1000;
      c.torque_max = 31'd1000;
      run_phase(c, 8, 1'b0);

      for (int p = 0; p < 10; p++) run_phase(random_valid_cfg(), 40, 1'b0);
      run_phase(CFG_RESET, 30, 1'b0);

      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
